// File: hw/rtl/slfp_pkg.sv
package slfp_pkg;

   // Field widths of the byte stream and of the result word.
   localparam int BYTE_W  = 8;
   localparam int KIND_W  = 3;
   localparam int RSP_W   = 4 * BYTE_W;
   localparam int CSR_A_W = 1;

   // Register reset values.
   localparam logic [BYTE_W-1:0] SYNC_RESET    = 8'hAA;
   localparam logic [BYTE_W-1:0] MAX_LEN_RESET = 8'hFF;

   // Register indexes on the csr port.
   localparam logic [CSR_A_W-1:0] CSR_SYNC_BYTE = 1'b0;
   localparam logic [CSR_A_W-1:0] CSR_MAX_LEN   = 1'b1;

   // Parser phase.
   typedef enum logic [2:0] {
      PH_HUNT = 3'd0,
      PH_CMD  = 3'd1,
      PH_LEN  = 3'd2,
      PH_DATA = 3'd3,
      PH_CHK  = 3'd4
   } phase_type;

   // Event codes carried on rsp_tuser.
   typedef enum logic [KIND_W-1:0] {
      EV_NONE    = 3'd0,
      EV_PAYLOAD = 3'd1,
      EV_GOOD    = 3'd2,
      EV_BAD     = 3'd3,
      EV_REJECT  = 3'd4
   } event_type;

   // One result word.
   typedef struct packed {
      logic [BYTE_W-1:0] payload_index;
      logic [BYTE_W-1:0] payload_byte;
      logic [BYTE_W-1:0] frame_len;
      logic [BYTE_W-1:0] frame_cmd;
      event_type         event_kind;
   } result_type;

endpackage

// File: hw/rtl/sync_len_xor_frame_parser.sv
// Frame parser for a received serial byte stream.
// The req channel carries one received byte per word. A frame is a sync byte,
// a command byte, a length byte, that many payload bytes and a checksum byte
// equal to the XOR of command, length and payload. Every accepted byte yields
// exactly one rsp word: an event code on rsp_tuser and the held command and
// length, plus the payload byte and its index for payload events.
// The csr port writes the sync value (index 0) and the largest accepted
// payload length (index 1); a write applies from the next byte.
// The result of a byte accepted at one edge is valid on rsp after that edge.
// Throughput is one byte per cycle while the receiver does not stall, set by
// the single result register behind the parser logic.
// Reset clears both registers to their defaults, returns the parser to sync
// hunting and empties the result register.
// When the receiver stalls, the held result stays on rsp and req_tready
// drops until the result is taken; no word is lost or repeated.
module sync_len_xor_frame_parser (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [slfp_pkg::BYTE_W-1:0]         req_tdata,  // rx_byte
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // frame_cmd, frame_len, payload_byte, payload_index
   output logic [slfp_pkg::RSP_W-1:0]          rsp_tdata,
   output logic [slfp_pkg::KIND_W-1:0]         rsp_tuser,  // event_kind
   input  logic                                csr_we,
   input  logic [slfp_pkg::CSR_A_W-1:0]        csr_addr,
   input  logic [slfp_pkg::BYTE_W-1:0]         csr_wdata
);

   slfp_pkg::result_type parse_result;
   slfp_pkg::result_type rsp_result;
   logic                 take;

   assign take = req_tvalid && req_tready;

   slfp_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .take      (take),
      .rx_byte   (req_tdata),
      .result    (parse_result)
   );

   slfp_out u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (parse_result),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_result)
   );

   // Pack the result word, frame_cmd in the lowest bits and payload_index in the highest.
   assign rsp_tdata = {rsp_result.payload_index, rsp_result.payload_byte,
                       rsp_result.frame_len, rsp_result.frame_cmd};
   assign rsp_tuser = rsp_result.event_kind;

endmodule

// File: hw/rtl/slfp_parse.sv
module slfp_parse (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [slfp_pkg::CSR_A_W-1:0]        csr_addr,
   input  logic [slfp_pkg::BYTE_W-1:0]         csr_wdata,
   input  logic                                take,
   input  logic [slfp_pkg::BYTE_W-1:0]         rx_byte,
   output slfp_pkg::result_type                result
);

   logic [slfp_pkg::BYTE_W-1:0] sync_ff;
   logic [slfp_pkg::BYTE_W-1:0] max_len_ff;

   slfp_pkg::phase_type         phase_ff, phase_in;
   logic [slfp_pkg::BYTE_W-1:0] cmd_ff, cmd_in;
   logic [slfp_pkg::BYTE_W-1:0] len_ff, len_in;
   logic [slfp_pkg::BYTE_W-1:0] count_ff, count_in;
   logic [slfp_pkg::BYTE_W-1:0] xor_ff, xor_in;
   logic [slfp_pkg::BYTE_W-1:0] count_next;

   // Configuration registers; a write takes effect from the next byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff    <= slfp_pkg::SYNC_RESET;
         max_len_ff <= slfp_pkg::MAX_LEN_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            slfp_pkg::CSR_SYNC_BYTE: sync_ff    <= csr_wdata;
            slfp_pkg::CSR_MAX_LEN:   max_len_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign count_next = count_ff + 8'd1;

   // Next state and the result for the current byte.
   always_comb begin
      phase_in             = phase_ff;
      cmd_in               = cmd_ff;
      len_in               = len_ff;
      count_in             = count_ff;
      xor_in               = xor_ff;
      result.event_kind    = slfp_pkg::EV_NONE;
      result.payload_byte  = '0;
      result.payload_index = '0;
      unique case (phase_ff)
         slfp_pkg::PH_CMD: begin
            cmd_in   = rx_byte;
            xor_in   = xor_ff ^ rx_byte;
            phase_in = slfp_pkg::PH_LEN;
         end
         slfp_pkg::PH_LEN: begin
            len_in   = rx_byte;
            xor_in   = xor_ff ^ rx_byte;
            count_in = '0;
            if (rx_byte == '0) begin
               // An empty frame goes straight to its checksum.
               phase_in = slfp_pkg::PH_CHK;
            end else if (rx_byte > max_len_ff) begin
               result.event_kind = slfp_pkg::EV_REJECT;
               phase_in          = slfp_pkg::PH_HUNT;
            end else begin
               phase_in = slfp_pkg::PH_DATA;
            end
         end
         slfp_pkg::PH_DATA: begin
            result.event_kind    = slfp_pkg::EV_PAYLOAD;
            result.payload_byte  = rx_byte;
            result.payload_index = count_ff;
            xor_in               = xor_ff ^ rx_byte;
            count_in             = count_next;
            if (count_next >= len_ff) begin
               phase_in = slfp_pkg::PH_CHK;
            end
         end
         slfp_pkg::PH_CHK: begin
            result.event_kind = (rx_byte == xor_ff) ? slfp_pkg::EV_GOOD : slfp_pkg::EV_BAD;
            phase_in          = slfp_pkg::PH_HUNT;
         end
         default: begin
            // Hunting: anything but the sync value is dropped.
            phase_in = slfp_pkg::PH_HUNT;
            if (rx_byte == sync_ff) begin
               xor_in   = '0;
               phase_in = slfp_pkg::PH_CMD;
            end
         end
      endcase
      result.frame_cmd = cmd_in;
      result.frame_len = len_in;
   end

   // Frame state advances only when a word is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= slfp_pkg::PH_HUNT;
         cmd_ff   <= '0;
         len_ff   <= '0;
         count_ff <= '0;
         xor_ff   <= '0;
      end else if (take) begin
         phase_ff <= phase_in;
         cmd_ff   <= cmd_in;
         len_ff   <= len_in;
         count_ff <= count_in;
         xor_ff   <= xor_in;
      end
   end

endmodule

// File: hw/rtl/slfp_out.sv
module slfp_out (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  slfp_pkg::result_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output slfp_pkg::result_type out_data
);

   logic                 valid_ff;
   slfp_pkg::result_type data_ff;

   // The register can load whenever it is empty or being drained.
   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= in_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// File: hw/rtl/slfp_checker.sv
module slfp_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [slfp_pkg::RSP_W-1:0]          rsp_tdata,
   input logic [slfp_pkg::KIND_W-1:0]         rsp_tuser
);

   // Reset empties the result register.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // Every accepted byte shows its result on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> rsp_tvalid)
      else $error("accepted byte produced no result");

   // Input is held off only while a result waits on a stalled receiver.
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("input stalled without a pending result");

   // A stalled result word holds.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled result changed");

   // A payload word lies inside the frame length.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == slfp_pkg::EV_PAYLOAD) |->
         (rsp_tdata[31:24] < rsp_tdata[15:8]))
      else $error("payload index beyond frame length");

endmodule

bind sync_len_xor_frame_parser slfp_checker u_slfp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// File: dv/sync_len_xor_frame_parser_tb.sv
`timescale 1ns / 100ps

module sync_len_xor_frame_parser_tb;

   // One byte of the stream, used for sizing random values.
   typedef logic [slfp_pkg::BYTE_W-1:0] byte_type;

   // Clock, reset and the block's inputs, all known from time zero.
   logic                          clock      = 1'b0;
   logic                          reset      = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic [slfp_pkg::BYTE_W-1:0]   req_tdata  = '0;
   logic                          rsp_tready = 1'b0;
   logic                          csr_we     = 1'b0;
   logic [slfp_pkg::CSR_A_W-1:0]  csr_addr   = '0;
   logic [slfp_pkg::BYTE_W-1:0]   csr_wdata  = '0;

   logic                          req_tready;
   logic                          rsp_tvalid;
   logic [slfp_pkg::RSP_W-1:0]    rsp_tdata;
   logic [slfp_pkg::KIND_W-1:0]   rsp_tuser;

   // Parser model state and its copy of the registers.
   slfp_pkg::phase_type           ph;
   logic [slfp_pkg::BYTE_W-1:0]   cmd_q;
   logic [slfp_pkg::BYTE_W-1:0]   len_q;
   logic [slfp_pkg::BYTE_W-1:0]   cnt_q;
   logic [slfp_pkg::BYTE_W-1:0]   xor_q;
   logic [slfp_pkg::BYTE_W-1:0]   sync_cfg;
   logic [slfp_pkg::BYTE_W-1:0]   maxlen_cfg;

   // Events predicted for accepted bytes, oldest first.
   slfp_pkg::result_type          expected_events[$];

   int                  error_count = 0;
   int                  sent_count  = 0;
   int                  burst_left  = 0;
   bit                  gaps_on     = 1'b1;

   sync_len_xor_frame_parser uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // Advance the parser model by one byte and return the event it causes.
   function automatic slfp_pkg::result_type parse_byte(input logic [slfp_pkg::BYTE_W-1:0] b);
      slfp_pkg::result_type r;
      r = '{event_kind: slfp_pkg::EV_NONE, default: '0};
      case (ph)
         slfp_pkg::PH_CMD: begin
            cmd_q = b;
            xor_q = xor_q ^ b;
            ph = slfp_pkg::PH_LEN;
         end
         slfp_pkg::PH_LEN: begin
            len_q = b;
            xor_q = xor_q ^ b;
            cnt_q = '0;
            if (b == 0) begin
               ph = slfp_pkg::PH_CHK;
            end else if (b > maxlen_cfg) begin
               r.event_kind = slfp_pkg::EV_REJECT;
               ph = slfp_pkg::PH_HUNT;
            end else begin
               ph = slfp_pkg::PH_DATA;
            end
         end
         slfp_pkg::PH_DATA: begin
            r.event_kind = slfp_pkg::EV_PAYLOAD;
            r.payload_byte = b;
            r.payload_index = cnt_q;
            xor_q = xor_q ^ b;
            cnt_q = cnt_q + 1'b1;
            if (cnt_q >= len_q) ph = slfp_pkg::PH_CHK;
         end
         slfp_pkg::PH_CHK: begin
            r.event_kind = (b == xor_q) ? slfp_pkg::EV_GOOD : slfp_pkg::EV_BAD;
            ph = slfp_pkg::PH_HUNT;
         end
         default: begin
            ph = slfp_pkg::PH_HUNT;
            if (b == sync_cfg) begin
               xor_q = '0;
               ph = slfp_pkg::PH_CMD;
            end
         end
      endcase
      r.frame_cmd = cmd_q;
      r.frame_len = len_q;
      return r;
   endfunction

   // Receiver: switches between always ready, random stalls and long stalls.
   int rx_mode   = 0;
   int mode_left = 0;
   int stall_left = 0;
   always @(posedge clock) begin
      if (mode_left == 0) begin
         rx_mode = $urandom_range(0, 2);
         mode_left = $urandom_range(50, 300);
      end else begin
         mode_left = mode_left - 1;
      end
      case (rx_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 9) < 7);
         default: begin
            if (stall_left > 0) begin
               stall_left = stall_left - 1;
               rsp_tready <= 1'b0;
            end else begin
               if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 12);
               rsp_tready <= 1'b1;
            end
         end
      endcase
   end

   // Compare every accepted result word with the oldest prediction.
   always @(posedge clock) begin
      slfp_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_events.size() == 0) begin
            $error("result word with no expectation waiting: kind %0d", rsp_tuser);
            error_count++;
         end else begin
            want = expected_events.pop_front();
            if (rsp_tuser !== want.event_kind) begin
               $error("event_kind mismatch: expected %0d, got %0d", want.event_kind, rsp_tuser);
               error_count++;
            end
            if (rsp_tdata[7:0] !== want.frame_cmd) begin
               $error("frame_cmd mismatch: expected %0h, got %0h",
                      want.frame_cmd, rsp_tdata[7:0]);
               error_count++;
            end
            if (rsp_tdata[15:8] !== want.frame_len) begin
               $error("frame_len mismatch: expected %0h, got %0h",
                      want.frame_len, rsp_tdata[15:8]);
               error_count++;
            end
            if (rsp_tdata[23:16] !== want.payload_byte) begin
               $error("payload_byte mismatch: expected %0h, got %0h",
                      want.payload_byte, rsp_tdata[23:16]);
               error_count++;
            end
            if (rsp_tdata[31:24] !== want.payload_index) begin
               $error("payload_index mismatch: expected %0h, got %0h",
                      want.payload_index, rsp_tdata[31:24]);
               error_count++;
            end
         end
      end
   end

   // Send one byte as a req word, with a random gap at the start of some bursts while gaps are on.
   task automatic send_byte(input logic [slfp_pkg::BYTE_W-1:0] b);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = 0;
         if (gaps_on && $urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      expected_events.push_back(parse_byte(b));
      sent_count++;
   endtask

   // Stop sending and wait until every predicted result has arrived.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (expected_events.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write both registers; only called while the parser is idle.
   task automatic set_config(input logic [slfp_pkg::BYTE_W-1:0] sync_val,
                             input logic [slfp_pkg::BYTE_W-1:0] maxlen_val);
      wait_idle();
      csr_we    <= 1'b1;
      csr_addr  <= slfp_pkg::CSR_SYNC_BYTE;
      csr_wdata <= sync_val;
      @(posedge clock);
      csr_addr  <= slfp_pkg::CSR_MAX_LEN;
      csr_wdata <= maxlen_val;
      @(posedge clock);
      csr_we    <= 1'b0;
      sync_cfg   = sync_val;
      maxlen_cfg = maxlen_val;
   endtask

   // Send one frame. A length over the limit stops after the length byte;
   // payload_cut >= 0 abandons the frame after that many payload bytes.
   task automatic send_frame(input logic [slfp_pkg::BYTE_W-1:0] cmd, input int len,
                             input bit bad_chk, input int payload_cut);
      logic [slfp_pkg::BYTE_W-1:0] chk;
      logic [slfp_pkg::BYTE_W-1:0] pb;
      chk = cmd ^ byte_type'(len);
      send_byte(sync_cfg);
      send_byte(cmd);
      send_byte(byte_type'(len));
      if (len != 0 && len > maxlen_cfg) return;
      for (int i = 0; i < len; i++) begin
         if (payload_cut >= 0 && i >= payload_cut) return;
         pb = byte_type'($urandom_range(0, 255));
         chk = chk ^ pb;
         send_byte(pb);
      end
      if (payload_cut >= 0) return;
      if (bad_chk) chk = chk ^ byte_type'($urandom_range(1, 255));
      send_byte(chk);
   endtask

   // Noise while hunting after reset, with the held fields still zero.
   task automatic test_hunt_idle();
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h55);
   endtask

   // Zero length, extreme bytes, a bad checksum and sync inside a frame.
   task automatic test_basic_frames();
      send_byte(sync_cfg);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(sync_cfg);
      send_byte(8'hFF);
      send_byte(8'h02);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(8'h02);
      send_byte(sync_cfg);
      send_byte(8'h5A);
      send_byte(8'h01);
      send_byte(sync_cfg);
      send_byte(8'h00);
   endtask

   // A length just over the limit, and zero length with a limit of zero.
   task automatic test_length_limits();
      set_config(slfp_pkg::SYNC_RESET, 8'd3);
      send_frame(8'h11, 4, 1'b0, -1);
      set_config(slfp_pkg::SYNC_RESET, 8'd0);
      send_frame(8'h22, 0, 1'b0, -1);
   endtask

   // Mostly well-formed frames with random content over several settings,
   // mixed with bad checksums, rejected lengths, cut frames and noise.
   task automatic test_random_traffic(input int total);
      int target;
      int len;
      int pick;
      bit big_done;
      big_done = 1'b0;
      target = sent_count;
      for (int p = 0; p < 5; p++) begin
         case (p)
            0: set_config(slfp_pkg::SYNC_RESET, slfp_pkg::MAX_LEN_RESET);
            1: set_config(8'h00, 8'h00);
            2: set_config(8'hFF, 8'h01);
            3: set_config(byte_type'($urandom_range(0, 255)),
                          byte_type'($urandom_range(1, 16)));
            default: set_config(byte_type'($urandom_range(0, 255)),
                                slfp_pkg::MAX_LEN_RESET);
         endcase
         gaps_on = (p != 1);
         target = target + total / 5;
         while (sent_count < target) begin
            pick = $urandom_range(0, 99);
            if (maxlen_cfg == 8'hFF && !big_done && p == 4) begin
               big_done = 1'b1;
               send_frame(byte_type'($urandom_range(0, 255)), 255, 1'b0, -1);
            end else if (pick < 8 && maxlen_cfg != 8'hFF) begin
               len = $urandom_range(maxlen_cfg + 1, 255);
               send_frame(byte_type'($urandom_range(0, 255)), len, 1'b0, -1);
            end else if (pick < 15) begin
               repeat ($urandom_range(1, 4)) send_byte(byte_type'($urandom_range(0, 255)));
            end else begin
               len = $urandom_range(0, (maxlen_cfg < 12) ? maxlen_cfg : 12);
               if (maxlen_cfg == 8'hFF && $urandom_range(0, 49) == 0)
                  len = $urandom_range(13, 255);
               if (pick < 20 && len > 0)
                  send_frame(byte_type'($urandom_range(0, 255)), len, 1'b0,
                             $urandom_range(0, len - 1));
               else
                  send_frame(byte_type'($urandom_range(0, 255)), len, (pick < 30), -1);
            end
            // Let everything drain in the middle of the third setting.
            if (p == 2 && sent_count > target - total / 10 && sent_count < target - total / 10 + 8)
               wait_idle();
         end
      end
   endtask

   // Reset, run the tests in turn, then wait for the last results.
   initial begin
      int i;
      ph         = slfp_pkg::PH_HUNT;
      cmd_q      = '0;
      len_q      = '0;
      cnt_q      = '0;
      xor_q      = '0;
      sync_cfg   = slfp_pkg::SYNC_RESET;
      maxlen_cfg = slfp_pkg::MAX_LEN_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_hunt_idle();
      test_basic_frames();
      test_length_limits();
      test_random_traffic(1300);

      req_tvalid <= 1'b0;
      i = 0;
      while (i < 5000 && expected_events.size() != 0) begin
         @(posedge clock);
         i++;
      end
      repeat (8) @(posedge clock);
      if (expected_events.size() != 0) begin
         $error("%0d expected result words never arrived", expected_events.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
